// ===== rtl/rect_occupancy_placer_top_assert.svh =====
// rect_occupancy_placer_top_assert.svh: assertion macros for the placer checker
// no dependencies; included by the checker file
`ifndef RECT_OCCUPANCY_PLACER_TOP_ASSERT_SVH
`define RECT_OCCUPANCY_PLACER_TOP_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define ROP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ROP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rop_pkg.sv =====
// rop_pkg: shared codes and fixed widths for the rectangle occupancy placer
// no dependencies; imported by rop_row_unit, the top level and the checker
package rop_pkg;

  // operation codes carried in the func field
  localparam logic [1:0] FUNC_TEST  = 2'd0;
  localparam logic [1:0] FUNC_PLACE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int ORIGIN_W = 4;
  localparam int SIZE_W   = 5;
  localparam int CFG_W    = 5;

  // port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 2;

  // width of bound sums and limits (effective grid side at most 31)
  localparam int CNT_W = 7;

  // reset value of both count registers
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

// ===== rtl/rop_ram.sv =====
// rop_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module rop_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== rtl/rop_row_unit.sv =====
// rop_row_unit: shared row unit, conflict test and set/clear of a column span
// depends on rop_pkg
module rop_row_unit
  import rop_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] row_word,
  input  logic [WIDTH-1:0] span_mask,
  input  logic             clr_en,
  output logic [WIDTH-1:0] new_word,
  output logic             conflict
);

  // any occupied cell under the span
  assign conflict = |(row_word & span_mask);

  // clear frees the span, otherwise the span is marked occupied
  assign new_word = clr_en ? (row_word & ~span_mask) : (row_word | span_mask);

endmodule

// ===== rtl/rect_occupancy_placer_top.sv =====
// rect_occupancy_placer_top: occupancy bitmap with rectangle test, place and clear
// depends on rop_pkg, rop_ram, rop_row_unit
//
// channel   direction  signals                         contents
// in_       slave      in_tvalid in_tready in_tdata    one request item
// out_      master     out_tvalid out_tready out_tdata one ok result item
// cfg_      write      cfg_wr_en cfg_addr cfg_wdata    column and row counts
//
// an item visits its rows twice at most: one read per row for the free check,
// then one read-modify-write per row for place or clear, through the ram's registered read
// in_tready rises with out_tvalid; a result waits in the result state only while
// the one before it is still unaccepted
// synchronous active-low reset clears the bitmap (row valid bits) and sets both counts to 16
module rect_occupancy_placer_top
  import rop_pkg::*;
#(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: func[1:0] origin_col[5:2] origin_row[9:6] rect_width[14:10]
  //           rect_height[19:15], zero fill above
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: ok[0], zero fill above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(MAX_COLS);
  localparam logic [CNT_W-1:0] ROWS_LIM = CNT_W'(MAX_ROWS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_FILL   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    cols_r, rows_r;
  logic [FUNC_W-1:0]   func_r;
  logic [MAX_COLS-1:0] mask_r;
  logic [RW-1:0]       start_row_r;
  logic [SIZE_W-1:0]   h_r;
  logic [RW-1:0]       iss_addr_r, iss_addr_nxt;
  logic [SIZE_W-1:0]   iss_left_r, iss_left_nxt;
  logic [RW-1:0]       ev_addr_r;
  logic                ev_pend_r, ev_pend_nxt;
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r;
  logic [MAX_ROWS-1:0] row_vld_r;
  logic                rv_r;

  // request fields
  logic [FUNC_W-1:0]   in_func;
  logic [ORIGIN_W-1:0] in_col, in_row;
  logic [SIZE_W-1:0]   in_w, in_h;

  assign in_func = in_tdata[1:0];
  assign in_col  = in_tdata[5:2];
  assign in_row  = in_tdata[9:6];
  assign in_w    = in_tdata[14:10];
  assign in_h    = in_tdata[19:15];

  // bounds against the effective counts
  logic [CNT_W-1:0]    ncols, nrows, col_end, row_end;
  logic                in_bounds;
  logic [MAX_COLS-1:0] in_mask;

  assign ncols   = ({2'b00, cols_r} > COLS_LIM) ? COLS_LIM : {2'b00, cols_r};
  assign nrows   = ({2'b00, rows_r} > ROWS_LIM) ? ROWS_LIM : {2'b00, rows_r};
  assign col_end = {3'b000, in_col} + {2'b00, in_w};
  assign row_end = {3'b000, in_row} + {2'b00, in_h};
  assign in_bounds = (col_end <= ncols) && (row_end <= nrows);

  // column span of the rectangle
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      in_mask[i] = (CNT_W'(i) >= {3'b000, in_col}) && (CNT_W'(i) < col_end);
    end
  end

  // handshakes and pass control
  logic in_fire, issue, pass_done, wr_en;
  logic in_pass;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_pass   = (state_r == S_CHECK) || (state_r == S_FILL);
  assign issue     = in_pass && (iss_left_r != '0);
  assign pass_done = (iss_left_r == '0) && !ev_pend_r;
  assign wr_en     = (state_r == S_FILL) && ev_pend_r;

  // bitmap storage and the shared row unit
  logic [MAX_COLS-1:0] rd_data, row_word, new_word;
  logic                conflict;

  rop_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(ev_addr_r),
    .wr_data(new_word),
    .rd_en  (issue),
    .rd_addr(iss_addr_r),
    .rd_data(rd_data)
  );

  // a row never written since reset reads as free
  assign row_word = rv_r ? rd_data : '0;

  rop_row_unit #(
    .WIDTH(MAX_COLS)
  ) u_row (
    .row_word (row_word),
    .span_mask(mask_r),
    .clr_en   (func_r == FUNC_CLEAR),
    .new_word (new_word),
    .conflict (conflict)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    iss_addr_nxt  = iss_addr_r;
    iss_left_nxt  = iss_left_r;
    ev_pend_nxt   = 1'b0;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          iss_addr_nxt = RW'(in_row);
          iss_left_nxt = in_h;
          ok_nxt       = in_bounds;
          if (!in_bounds) begin
            state_nxt = S_RESULT;
          end else if (in_func == FUNC_CLEAR) begin
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK, S_FILL: begin
        if (issue) begin
          iss_addr_nxt = iss_addr_r + RW'(1);
          iss_left_nxt = iss_left_r - SIZE_W'(1);
          ev_pend_nxt  = 1'b1;
        end
        if ((state_r == S_CHECK) && ev_pend_r && conflict) begin
          ok_nxt = 1'b0;
        end
        if (pass_done) begin
          if ((state_r == S_CHECK) && ok_r && (func_r == FUNC_PLACE)) begin
            state_nxt    = S_FILL;
            iss_addr_nxt = start_row_r;
            iss_left_nxt = h_r;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      cols_r      <= CFG_RESET;
      rows_r      <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      ev_pend_r   <= ev_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        row_vld_r[ev_addr_r] <= 1'b1;
      end
      if (cfg_wr_en) begin
        if (cfg_addr == REG_COLS) begin
          cols_r <= cfg_wdata;
        end else if (cfg_addr == REG_ROWS) begin
          rows_r <= cfg_wdata;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    iss_addr_r <= iss_addr_nxt;
    iss_left_r <= iss_left_nxt;
    ok_r       <= ok_nxt;
    if (in_fire) begin
      func_r      <= in_func;
      mask_r      <= in_mask;
      start_row_r <= RW'(in_row);
      h_r         <= in_h;
    end
    if (issue) begin
      ev_addr_r <= iss_addr_r;
      rv_r      <= row_vld_r[iss_addr_r];
    end
    if ((state_r == S_RESULT) && (!out_valid_r || out_tready)) begin
      out_ok_r <= ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_ok_r};

endmodule

// ===== rtl/rop_checker.sv =====
// rop_checker: port-level assertions for the placer, bound to the top level
// depends on rop_pkg and rect_occupancy_placer_top_assert.svh
`include "rect_occupancy_placer_top_assert.svh"

module rop_checker
  import rop_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // an accepted item keeps the block busy for at least the next cycle
  `ROP_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "accepted item did not make the block busy")

  // a waiting result holds its value
  `ROP_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed or dropped")

  // a new result only follows work in progress
  `ROP_ASSERT(a_result_after_work, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready), "result appeared without a request in work")

  // reset leaves the block idle with no result pending
  `ROP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_tvalid && in_tready), "block not idle after reset")

endmodule

bind rect_occupancy_placer_top rop_checker u_rop_checker (.*);
